@@ hw/rtl/sprite_slot_pool_update_core_assert.svh @@
// Assertion macros used by the core RTL
`ifndef SPRITE_SLOT_POOL_UPDATE_CORE_ASSERT_SVH
`define SPRITE_SLOT_POOL_UPDATE_CORE_ASSERT_SVH

// same-cycle implication
`define SSPU_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define SSPU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

@@ hw/rtl/sspu_pkg.sv @@
`default_nettype none

package sspu_pkg;

   localparam int POS_W   = 16;
   localparam int VEL_W   = 9;
   localparam int DIM_W   = 6;
   localparam int SIZE_W  = 12;
   localparam int LIFE_W  = 14;
   localparam int TIME_W  = 32;
   localparam int FRAME_W = 2;
   localparam int BOUND_W = 12;
   localparam int PER_W   = 16;
   localparam int ORIG_W  = 10;
   localparam int FWID_W  = 8;
   localparam int SHEET_W = 12;
   localparam int SLOT_OUT_W = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // opcodes and report kinds
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_SPAWN   = 1'b1;
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_SPAWN = 1'b1;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_LOW       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_HIGH      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_LOW       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_HIGH      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANIM_PERIOD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ORIG  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 3'd6;

   // CSR reset values
   localparam logic [BOUND_W-1:0] RST_X_LOW       = 12'd0;
   localparam logic [BOUND_W-1:0] RST_X_HIGH      = 12'd800;
   localparam logic [BOUND_W-1:0] RST_Y_LOW       = 12'd0;
   localparam logic [BOUND_W-1:0] RST_Y_HIGH      = 12'd600;
   localparam logic [PER_W-1:0]   RST_ANIM_PERIOD = 16'd100;
   localparam logic [ORIG_W-1:0]  RST_FRAME_ORIG  = 10'd0;
   localparam logic [FWID_W-1:0]  RST_FRAME_WIDTH = 8'd64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_SPAWN
   } state_type;

   typedef struct packed {
      logic [BOUND_W-1:0] x_low;
      logic [BOUND_W-1:0] x_high;
      logic [BOUND_W-1:0] y_low;
      logic [BOUND_W-1:0] y_high;
      logic [PER_W-1:0]   anim_period;
      logic [ORIG_W-1:0]  frame_origin_x;
      logic [FWID_W-1:0]  frame_width;
   } cfg_type;

   // one slot as held in the slot memory; size: height in [11:6], width in [5:0]
   typedef struct packed {
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [VEL_W-1:0]   vel_x;
      logic [VEL_W-1:0]   vel_y;
      logic [SIZE_W-1:0]  size;
      logic [LIFE_W-1:0]  life;
      logic [TIME_W-1:0]  born;
      logic [TIME_W-1:0]  stamp;
      logic [FRAME_W-1:0] frame;
   } slot_entry_type;

   typedef struct packed {
      logic               alive;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [SHEET_W-1:0] sheet_x;
   } rpt_type;

endpackage

`default_nettype wire

@@ hw/rtl/sspu_slot_mem.sv @@
`default_nettype none

// slot store: one write port, one read port, registered read data
module sspu_slot_mem #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  wire                         clock,
   input  wire                         wr_en,
   input  wire  [ADDR_W-1:0]           wr_addr,
   input  sspu_pkg::slot_entry_type    wr_data,
   input  wire                         rd_en,
   input  wire  [ADDR_W-1:0]           rd_addr,
   output sspu_pkg::slot_entry_type    rd_data
);

   sspu_pkg::slot_entry_type mem [DEPTH];
   sspu_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/sspu_slot_update.sv @@
`default_nettype none

// per-slot tick step: expiry, move and bounce, frame advance, report
module sspu_slot_update #(
   parameter int FRAMES = 4
) (
   input  wire                         live,
   input  sspu_pkg::slot_entry_type    entry,
   input  sspu_pkg::cfg_type           cfg,
   input  wire  [sspu_pkg::TIME_W-1:0] now,
   output logic                        alive,
   output sspu_pkg::slot_entry_type    entry_out,
   output sspu_pkg::rpt_type           rpt
);

   localparam int POS_W   = sspu_pkg::POS_W;
   localparam int VEL_W   = sspu_pkg::VEL_W;
   localparam int FRAME_W = sspu_pkg::FRAME_W;
   localparam int TIME_W  = sspu_pkg::TIME_W;

   logic [POS_W-1:0]   px_new, py_new;
   logic [POS_W-1:0]   lo_x, hi_x, lo_y, hi_y;
   logic               out_x, out_y;
   logic [TIME_W-1:0]  age, since_frame;
   logic               expired, frame_due;
   logic [FRAME_W-1:0] frame_new;
   logic [9:0]         frame_off;
   logic [sspu_pkg::SHEET_W-1:0] sheet;

   always_comb begin
      px_new = entry.pos_x + {{(POS_W-VEL_W){entry.vel_x[VEL_W-1]}}, entry.vel_x};
      py_new = entry.pos_y + {{(POS_W-VEL_W){entry.vel_y[VEL_W-1]}}, entry.vel_y};
      // bounds are whole pixels, positions carry 4 fraction bits
      lo_x = {cfg.x_low, 4'b0000};
      hi_x = {cfg.x_high, 4'b0000};
      lo_y = {cfg.y_low, 4'b0000};
      hi_y = {cfg.y_high, 4'b0000};
      out_x = ($signed(px_new) < $signed(lo_x)) || ($signed(px_new) > $signed(hi_x));
      out_y = ($signed(py_new) < $signed(lo_y)) || ($signed(py_new) > $signed(hi_y));

      age         = now - entry.born;
      since_frame = now - entry.stamp;
      expired     = age > {{(TIME_W-sspu_pkg::LIFE_W){1'b0}}, entry.life};
      frame_due   = since_frame > {{(TIME_W-sspu_pkg::PER_W){1'b0}}, cfg.anim_period};
      alive       = live && !expired;

      if (!frame_due) begin
         frame_new = entry.frame;
      end else if (entry.frame == FRAME_W'(FRAMES - 1)) begin
         frame_new = '0;
      end else begin
         frame_new = entry.frame + FRAME_W'(1);
      end

      frame_off = 10'(frame_new) * 10'(cfg.frame_width);
      sheet     = {2'b00, cfg.frame_origin_x} + {2'b00, frame_off};

      entry_out       = entry;
      entry_out.pos_x = px_new;
      entry_out.pos_y = py_new;
      entry_out.vel_x = out_x ? (~entry.vel_x + VEL_W'(1)) : entry.vel_x;
      entry_out.vel_y = out_y ? (~entry.vel_y + VEL_W'(1)) : entry.vel_y;
      entry_out.stamp = frame_due ? now : entry.stamp;
      entry_out.frame = frame_new;

      rpt = '0;
      if (alive) begin
         rpt.alive   = 1'b1;
         rpt.pos_x   = px_new;
         rpt.pos_y   = py_new;
         rpt.width   = entry.size[5:0];
         rpt.height  = entry.size[11:6];
         rpt.sheet_x = sheet;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/sprite_slot_pool_update_core.sv @@
// Tick: one report per slot, in slot order, each behind a registered memory read.
// Spawn: walks the live flags from slot 0, one per cycle while not stalled, then one report.
// The slot memory's single read port and read-modify-write set one slot per cycle, if unstalled.
// A new request is taken once the previous one has loaded its final report.
// Reset (synchronous, active high) clears live flags, control and CSRs to defaults;
// the slot memory itself is not cleared.
`default_nettype none

`include "sprite_slot_pool_update_core_assert.svh"

module sprite_slot_pool_update_core #(
   parameter int SLOTS  = 32,
   parameter int FRAMES = 4
) (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire                               req_opcode,
   input  wire  [sspu_pkg::TIME_W-1:0]       req_now,
   input  wire  signed [sspu_pkg::VEL_W-1:0] req_vel_x,
   input  wire  signed [sspu_pkg::VEL_W-1:0] req_vel_y,
   input  wire  [sspu_pkg::DIM_W-1:0]        req_width_in,
   input  wire  [sspu_pkg::DIM_W-1:0]        req_height_in,
   input  wire  [sspu_pkg::LIFE_W-1:0]       req_life_in,
   // response channel
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic                              rsp_kind,
   output logic [sspu_pkg::SLOT_OUT_W-1:0]   rsp_slot,
   output logic                              rsp_alive,
   output logic signed [sspu_pkg::POS_W-1:0] rsp_pos_x,
   output logic signed [sspu_pkg::POS_W-1:0] rsp_pos_y,
   output logic [sspu_pkg::DIM_W-1:0]        rsp_width_out,
   output logic [sspu_pkg::DIM_W-1:0]        rsp_height_out,
   output logic [sspu_pkg::SHEET_W-1:0]      rsp_sheet_x,
   output logic                              rsp_last,
   // CSR write port
   input  wire                               csr_wr_en,
   input  wire  [sspu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [sspu_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);

   // ---------------------------------------------------------------- CSRs
   sspu_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_low          <= sspu_pkg::RST_X_LOW;
         cfg_ff.x_high         <= sspu_pkg::RST_X_HIGH;
         cfg_ff.y_low          <= sspu_pkg::RST_Y_LOW;
         cfg_ff.y_high         <= sspu_pkg::RST_Y_HIGH;
         cfg_ff.anim_period    <= sspu_pkg::RST_ANIM_PERIOD;
         cfg_ff.frame_origin_x <= sspu_pkg::RST_FRAME_ORIG;
         cfg_ff.frame_width    <= sspu_pkg::RST_FRAME_WIDTH;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sspu_pkg::CSR_X_LOW:       cfg_ff.x_low          <= csr_wdata[11:0];
            sspu_pkg::CSR_X_HIGH:      cfg_ff.x_high         <= csr_wdata[11:0];
            sspu_pkg::CSR_Y_LOW:       cfg_ff.y_low          <= csr_wdata[11:0];
            sspu_pkg::CSR_Y_HIGH:      cfg_ff.y_high         <= csr_wdata[11:0];
            sspu_pkg::CSR_ANIM_PERIOD: cfg_ff.anim_period    <= csr_wdata;
            sspu_pkg::CSR_FRAME_ORIG:  cfg_ff.frame_origin_x <= csr_wdata[9:0];
            sspu_pkg::CSR_FRAME_WIDTH: cfg_ff.frame_width    <= csr_wdata[7:0];
            default: ; // unused index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- state
   sspu_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;        // next slot to read / test
   logic [SLOT_W-1:0]   scan_idx;
   logic                rd_vld_ff, rd_vld_in;    // memory read data is for proc_idx_ff
   logic [SLOT_W-1:0]   proc_idx_ff, proc_idx_in;
   logic                proc_last;
   logic                live_ff [SLOTS];

   // latched request
   logic [sspu_pkg::TIME_W-1:0]  now_ff;
   logic [sspu_pkg::VEL_W-1:0]   vel_x_ff, vel_y_ff;
   logic [sspu_pkg::DIM_W-1:0]   width_ff, height_ff;
   logic [sspu_pkg::LIFE_W-1:0]  life_ff;

   // output register
   logic                             rsp_valid_ff;
   logic                             rsp_kind_ff, rsp_last_ff;
   logic [sspu_pkg::SLOT_OUT_W-1:0]  rsp_slot_ff;
   sspu_pkg::rpt_type                rsp_rpt_ff;

   logic req_fire, out_free;

   // memory and update unit hook-up
   logic                        mem_wr_en, mem_rd_en;
   logic [SLOT_W-1:0]           mem_wr_addr;
   sspu_pkg::slot_entry_type    mem_wr_data, mem_rd_data;
   sspu_pkg::slot_entry_type    upd_entry, spawn_entry;
   sspu_pkg::rpt_type           upd_rpt, spawn_rpt;
   logic                        upd_alive;

   // live flag and output load controls
   logic                        live_set, live_clr;
   logic [SLOT_W-1:0]           live_addr;
   logic                        out_load;
   logic                        out_kind_in, out_last_in;
   logic [sspu_pkg::SLOT_OUT_W-1:0] out_slot_in;
   sspu_pkg::rpt_type           out_rpt_in;

   assign scan_idx  = scan_ff[SLOT_W-1:0];
   assign proc_last = (proc_idx_ff == SLOT_W'(SLOTS - 1));
   assign req_stall = (state_ff != sspu_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   // output register is free when empty or its transfer completes this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // fresh slot built from the latched spawn request
   always_comb begin
      spawn_entry       = '0;
      spawn_entry.vel_x = vel_x_ff;
      spawn_entry.vel_y = vel_y_ff;
      spawn_entry.size  = {height_ff, width_ff};
      spawn_entry.life  = life_ff;
      spawn_entry.born  = now_ff;
      spawn_entry.stamp = now_ff;

      spawn_rpt         = '0;
      spawn_rpt.alive   = 1'b1;
      spawn_rpt.width   = width_ff;
      spawn_rpt.height  = height_ff;
      spawn_rpt.sheet_x = {2'b00, cfg_ff.frame_origin_x};
   end

   sspu_slot_mem #(
      .DEPTH  (SLOTS),
      .ADDR_W (SLOT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (scan_idx),
      .rd_data (mem_rd_data)
   );

   sspu_slot_update #(
      .FRAMES (FRAMES)
   ) u_update (
      .live      (live_ff[proc_idx_ff]),
      .entry     (mem_rd_data),
      .cfg       (cfg_ff),
      .now       (now_ff),
      .alive     (upd_alive),
      .entry_out (upd_entry),
      .rpt       (upd_rpt)
   );

   // ---------------------------------------------------------------- control
   // Tick is a two-stage sweep: read slot n while slot n-1 is updated and
   // written back. Read and write never hit the same slot, so no forwarding.
   // Everything holds while the output register is stalled.
   always_comb begin
      state_in    = state_ff;
      scan_in     = scan_ff;
      rd_vld_in   = rd_vld_ff;
      proc_idx_in = proc_idx_ff;
      mem_rd_en   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = proc_idx_ff;
      mem_wr_data = upd_entry;
      live_set    = 1'b0;
      live_clr    = 1'b0;
      live_addr   = proc_idx_ff;
      out_load    = 1'b0;
      out_kind_in = sspu_pkg::KIND_TICK;
      out_slot_in = sspu_pkg::SLOT_OUT_W'(proc_idx_ff);
      out_last_in = proc_last;
      out_rpt_in  = upd_rpt;

      unique case (state_ff)
         sspu_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in  = (req_opcode == sspu_pkg::OP_SPAWN) ? sspu_pkg::ST_SPAWN
                                                             : sspu_pkg::ST_TICK;
               scan_in   = '0;
               rd_vld_in = 1'b0;
            end
         end
         sspu_pkg::ST_TICK: begin
            if (out_free) begin
               if (rd_vld_ff) begin
                  out_load  = 1'b1;
                  mem_wr_en = upd_alive;
                  live_clr  = !upd_alive;
                  if (proc_last) begin
                     state_in = sspu_pkg::ST_IDLE;
                  end
               end
               if (scan_ff < CNT_W'(SLOTS)) begin
                  mem_rd_en   = 1'b1;
                  proc_idx_in = scan_idx;
                  scan_in     = scan_ff + CNT_W'(1);
                  rd_vld_in   = 1'b1;
               end else begin
                  rd_vld_in = 1'b0;
               end
            end
         end
         sspu_pkg::ST_SPAWN: begin
            if (out_free) begin
               out_kind_in = sspu_pkg::KIND_SPAWN;
               out_last_in = 1'b1;
               if (!live_ff[scan_idx]) begin
                  // lowest free slot: claim it
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = scan_idx;
                  mem_wr_data = spawn_entry;
                  live_set    = 1'b1;
                  live_addr   = scan_idx;
                  out_load    = 1'b1;
                  out_slot_in = sspu_pkg::SLOT_OUT_W'(scan_idx);
                  out_rpt_in  = spawn_rpt;
                  state_in    = sspu_pkg::ST_IDLE;
               end else if (scan_idx == SLOT_W'(SLOTS - 1)) begin
                  // pool full
                  out_load    = 1'b1;
                  out_slot_in = '0;
                  out_rpt_in  = '0;
                  state_in    = sspu_pkg::ST_IDLE;
               end else begin
                  scan_in = scan_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = sspu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sspu_pkg::ST_IDLE;
         scan_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         proc_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         scan_ff     <= scan_in;
         rd_vld_ff   <= rd_vld_in;
         proc_idx_ff <= proc_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            live_ff[i] <= 1'b0;
         end
      end else if (live_set) begin
         live_ff[live_addr] <= 1'b1;
      end else if (live_clr) begin
         live_ff[live_addr] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff    <= req_now;
         vel_x_ff  <= req_vel_x;
         vel_y_ff  <= req_vel_y;
         width_ff  <= req_width_in;
         height_ff <= req_height_in;
         life_ff   <= req_life_in;
      end
   end

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff <= out_kind_in;
         rsp_slot_ff <= out_slot_in;
         rsp_last_ff <= out_last_in;
         rsp_rpt_ff  <= out_rpt_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_alive      = rsp_rpt_ff.alive;
   assign rsp_pos_x      = rsp_rpt_ff.pos_x;
   assign rsp_pos_y      = rsp_rpt_ff.pos_y;
   assign rsp_width_out  = rsp_rpt_ff.width;
   assign rsp_height_out = rsp_rpt_ff.height;
   assign rsp_sheet_x    = rsp_rpt_ff.sheet_x;
   assign rsp_last       = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   `SSPU_ASSERT_IMPLIES(a_tick_last_is_top_slot, clock, reset, rsp_valid_ff && rsp_last_ff && (rsp_kind_ff == sspu_pkg::KIND_TICK), rsp_slot_ff == sspu_pkg::SLOT_OUT_W'(SLOTS - 1))
   `SSPU_ASSERT_NEXT(a_claim_sets_live, clock, reset, live_set, live_ff[$past(live_addr)])
   `SSPU_ASSERT_IMPLIES(a_write_only_busy, clock, reset, mem_wr_en, state_ff != sspu_pkg::ST_IDLE)
   `SSPU_ASSERT_IMPLIES(a_no_rw_same_slot, clock, reset, mem_rd_en && mem_wr_en, mem_wr_addr != scan_idx)

endmodule

`default_nettype wire

@@ verif/sprite_slot_pool_update_core_test.sv @@
module sprite_slot_pool_update_core_test;

   localparam int SLOTS       = 32;
   localparam int FRAMES      = 4;
   localparam int CYCLE_LIMIT = 1_000_000;
   // long receiver hold-off, long enough for a tick to back up into the request side
   localparam int HOLD_CYCLES = 300;
   // enough spawns to fill the pool and then be refused
   localparam int CROWD       = SLOTS + 2;

   // opcodes as used in the directed table
   localparam logic OP_TICK  = sspu_pkg::OP_TICK;
   localparam logic OP_SPAWN = sspu_pkg::OP_SPAWN;

   typedef struct packed {
      logic        op;
      logic [31:0] now;
      logic [8:0]  vx;
      logic [8:0]  vy;
      logic [5:0]  w;
      logic [5:0]  h;
      logic [13:0] life;
   } sprite_req_type;

   typedef struct packed {
      logic        kind;
      logic [5:0]  slot;
      logic        alive;
      logic [15:0] px;
      logic [15:0] py;
      logic [5:0]  w;
      logic [5:0]  h;
      logic [11:0] sheet;
      logic        last;
   } slot_report_type;

   // how a directed row is checked: by the pool model, or against a value typed in
   typedef enum {CHK_MODEL, CHK_EMPTY_POOL, CHK_CLAIM} row_check_type;

   typedef struct {
      sprite_req_type req;
      row_check_type  chk;
      int             slot;
   } plan_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_opcode;
   logic [31:0]         req_now;
   logic signed [8:0]   req_vel_x;
   logic signed [8:0]   req_vel_y;
   logic [5:0]          req_width_in;
   logic [5:0]          req_height_in;
   logic [13:0]         req_life_in;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_kind;
   logic [5:0]          rsp_slot;
   logic                rsp_alive;
   logic signed [15:0]  rsp_pos_x;
   logic signed [15:0]  rsp_pos_y;
   logic [5:0]          rsp_width_out;
   logic [5:0]          rsp_height_out;
   logic [11:0]         rsp_sheet_x;
   logic                rsp_last;
   logic                csr_wr_en;
   logic [2:0]          csr_index;
   logic [15:0]         csr_wdata;

   sprite_slot_pool_update_core #(
      .SLOTS  (SLOTS),
      .FRAMES (FRAMES)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_now        (req_now),
      .req_vel_x      (req_vel_x),
      .req_vel_y      (req_vel_y),
      .req_width_in   (req_width_in),
      .req_height_in  (req_height_in),
      .req_life_in    (req_life_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_slot       (rsp_slot),
      .rsp_alive      (rsp_alive),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_width_out  (rsp_width_out),
      .rsp_height_out (rsp_height_out),
      .rsp_sheet_x    (rsp_sheet_x),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Pool model: own copy of every slot and of the registers
   // ---------------------------------------------------------------------------
   logic               pool_live  [SLOTS];
   logic [15:0]        pool_px    [SLOTS];
   logic [15:0]        pool_py    [SLOTS];
   logic [8:0]         pool_vx    [SLOTS];
   logic [8:0]         pool_vy    [SLOTS];
   logic [5:0]         pool_w     [SLOTS];
   logic [5:0]         pool_h     [SLOTS];
   logic [13:0]        pool_life  [SLOTS];
   logic [31:0]        pool_born  [SLOTS];
   logic [31:0]        pool_stamp [SLOTS];
   logic [1:0]         pool_frame [SLOTS];

   logic signed [11:0] bound_x_lo;
   logic signed [11:0] bound_x_hi;
   logic signed [11:0] bound_y_lo;
   logic signed [11:0] bound_y_hi;
   logic [15:0]        anim_period;
   logic [9:0]         sheet_origin;
   logic [7:0]         sheet_step;

   slot_report_type    pending_reports[$];
   int                 error_count;
   int                 cycle_count;
   logic [31:0]        clock_ms;
   bit                 quiet;          // final stretch: no idling on either side
   bit                 hold_request;   // asks the receiver for one long hold-off

   function automatic logic [11:0] sheet_pos(logic [1:0] frame);
      return 12'(sheet_origin) + 12'(frame) * 12'(sheet_step);
   endfunction

   // move one axis, then flip velocity if the new position is outside the bounds
   // (bounds are integer pixels, position carries 4 fraction bits)
   function automatic void bounce(inout logic [15:0] pos, inout logic [8:0] vel,
                                  input logic signed [11:0] lo,
                                  input logic signed [11:0] hi);
      logic signed [15:0] moved;
      int lo_lim;
      int hi_lim;
      moved  = pos + {{7{vel[8]}}, vel};
      lo_lim = lo;
      hi_lim = hi;
      lo_lim = lo_lim * 16;
      hi_lim = hi_lim * 16;
      pos    = moved;
      if (moved < lo_lim || moved > hi_lim) vel = -vel;
   endfunction

   // apply one request to the pool; queue its reports when asked to
   function automatic void advance_pool(sprite_req_type r, bit record);
      slot_report_type rpt;
      int              claimed;
      claimed = -1;
      if (r.op == sspu_pkg::OP_SPAWN) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (!pool_live[i] && claimed < 0) claimed = i;
         end
         rpt = '0;
         rpt.kind = sspu_pkg::KIND_SPAWN;
         rpt.last = 1'b1;
         if (claimed >= 0) begin
            pool_live[claimed]  = 1'b1;
            pool_px[claimed]    = '0;
            pool_py[claimed]    = '0;
            pool_vx[claimed]    = r.vx;
            pool_vy[claimed]    = r.vy;
            pool_w[claimed]     = r.w;
            pool_h[claimed]     = r.h;
            pool_life[claimed]  = r.life;
            pool_born[claimed]  = r.now;
            pool_stamp[claimed] = r.now;
            pool_frame[claimed] = '0;
            rpt.slot  = 6'(claimed);
            rpt.alive = 1'b1;
            rpt.w     = r.w;
            rpt.h     = r.h;
            rpt.sheet = sheet_pos(2'd0);
         end
         if (record) pending_reports.push_back(rpt);
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            rpt = '0;
            rpt.kind = sspu_pkg::KIND_TICK;
            rpt.slot = 6'(i);
            rpt.last = (i == SLOTS - 1);
            // elapsed time wraps at 32 bits
            if (pool_live[i] && (r.now - pool_born[i]) > 32'(pool_life[i]))
               pool_live[i] = 1'b0;
            if (pool_live[i]) begin
               bounce(pool_px[i], pool_vx[i], bound_x_lo, bound_x_hi);
               bounce(pool_py[i], pool_vy[i], bound_y_lo, bound_y_hi);
               if ((r.now - pool_stamp[i]) > 32'(anim_period)) begin
                  pool_stamp[i] = r.now;
                  pool_frame[i] = 2'((pool_frame[i] + 1) % FRAMES);
               end
               rpt.alive = 1'b1;
               rpt.px    = pool_px[i];
               rpt.py    = pool_py[i];
               rpt.w     = pool_w[i];
               rpt.h     = pool_h[i];
               rpt.sheet = sheet_pos(pool_frame[i]);
            end
            if (record) pending_reports.push_back(rpt);
         end
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Directed table: run straight after reset with the reset register values.
   // Claims and the empty pool are typed in; the rest goes through the model.
   // ---------------------------------------------------------------------------
   plan_row_type plan[20] = '{
      // empty pool straight after reset: every report is blank
      '{'{OP_TICK,  32'd0,         9'h000, 9'h000, 6'd0,  6'd0,  14'd0},    CHK_EMPTY_POOL, 0},
      // velocity extremes, widest and zero sizes, longest and zero lifetimes
      '{'{OP_SPAWN, 32'd1000,      9'h0FF, 9'h100, 6'd63, 6'd0,  14'h3FFF}, CHK_CLAIM, 0},
      '{'{OP_SPAWN, 32'd1000,      9'h100, 9'h0FF, 6'd0,  6'd63, 14'd0},    CHK_CLAIM, 1},
      '{'{OP_SPAWN, 32'd1000,      9'h010, 9'h010, 6'd8,  6'd40, 14'd500},  CHK_CLAIM, 2},
      // born just before the time wraps
      '{'{OP_SPAWN, 32'hFFFF_FFF0, 9'h000, 9'h000, 6'd40, 6'd8,  14'h3FFF}, CHK_CLAIM, 3},
      // -256 bounces off the left bound and stays -256; zero lifetime survives zero elapsed
      '{'{OP_TICK,  32'd1000,      9'h000, 9'h000, 6'd0,  6'd0,  14'd0},    CHK_MODEL, 0},
      '{'{OP_TICK,  32'd1001,      9'h000, 9'h000, 6'd0,  6'd0,  14'd0},    CHK_MODEL, 0},
      // period exceeded by one: frame steps
      '{'{OP_TICK,  32'd1101,      9'h000, 9'h000, 6'd0,  6'd0,  14'd0},    CHK_MODEL, 0},
      '{'{OP_TICK,  32'd1102,      9'h000, 9'h000, 6'd0,  6'd0,  14'd0},    CHK_MODEL, 0},
      // the freed slot is the lowest inactive one
      '{'{OP_SPAWN, 32'd1102,      9'h1F0, 9'h030, 6'd20, 6'd20, 14'h3FFF}, CHK_CLAIM, 1},
      '{'{OP_TICK,  32'd1600,      9'h000, 9'h000, 6'd0,  6'd0,  14'd0},    CHK_MODEL, 0},
      // frame index walks round and wraps
      '{'{OP_TICK,  32'd1701,      9'h000, 9'h000, 6'd0,  6'd0,  14'd0},    CHK_MODEL, 0},
      '{'{OP_TICK,  32'd1802,      9'h000, 9'h000, 6'd0,  6'd0,  14'd0},    CHK_MODEL, 0},
      '{'{OP_TICK,  32'd1903,      9'h000, 9'h000, 6'd0,  6'd0,  14'd0},    CHK_MODEL, 0},
      '{'{OP_SPAWN, 32'd2000,      9'h07F, 9'h181, 6'd63, 6'd63, 14'h3FFF}, CHK_CLAIM, 2},
      // elapsed equals lifetime: still alive; one more and it expires
      '{'{OP_TICK,  32'd18383,     9'h000, 9'h000, 6'd0,  6'd0,  14'd0},    CHK_MODEL, 0},
      '{'{OP_TICK,  32'd18384,     9'h000, 9'h000, 6'd0,  6'd0,  14'd0},    CHK_MODEL, 0},
      // elapsed time across the 32-bit wrap
      '{'{OP_SPAWN, 32'hFFFF_FFFF, 9'h001, 9'h1FF, 6'd16, 6'd16, 14'd10},   CHK_CLAIM, 0},
      '{'{OP_TICK,  32'd9,         9'h000, 9'h000, 6'd0,  6'd0,  14'd0},    CHK_MODEL, 0},
      '{'{OP_TICK,  32'd10,        9'h000, 9'h000, 6'd0,  6'd0,  14'd0},    CHK_MODEL, 0}
   };

   // ---------------------------------------------------------------------------
   // Clock, cycle limit
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off on request.
   // Stall only changes at the falling edge.
   // ---------------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Report checker: each transfer on the response side against the oldest
   // expectation, field by field
   // ---------------------------------------------------------------------------
   task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      slot_report_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: report for slot %0d with nothing expected, expected none, got %0h",
                     $time, rsp_slot, rsp_kind);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("kind",       16'(want.kind),  16'(rsp_kind));
            check_field("slot",       16'(want.slot),  16'(rsp_slot));
            check_field("alive",      16'(want.alive), 16'(rsp_alive));
            check_field("pos_x",      want.px,         rsp_pos_x);
            check_field("pos_y",      want.py,         rsp_pos_y);
            check_field("width_out",  16'(want.w),     16'(rsp_width_out));
            check_field("height_out", 16'(want.h),     16'(rsp_height_out));
            check_field("sheet_x",    16'(want.sheet), 16'(rsp_sheet_x));
            check_field("last",       16'(want.last),  16'(rsp_last));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side. Inputs change at the falling edge; a transfer is seen at the
   // rising edge, and its reports are queued there, before any can come out.
   // ---------------------------------------------------------------------------
   task automatic transfer_item(input sprite_req_type r, input row_check_type chk,
                                input int claim);
      slot_report_type note;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_opcode    = r.op;
      req_now       = r.now;
      req_vel_x     = r.vx;
      req_vel_y     = r.vy;
      req_width_in  = r.w;
      req_height_in = r.h;
      req_life_in   = r.life;
      req_valid     = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (chk)
         CHK_MODEL: begin
            advance_pool(r, 1'b1);
         end
         CHK_EMPTY_POOL: begin
            advance_pool(r, 1'b0);
            for (int i = 0; i < SLOTS; i++) begin
               note = '0;
               note.kind = sspu_pkg::KIND_TICK;
               note.slot = 6'(i);
               note.last = (i == SLOTS - 1);
               pending_reports.push_back(note);
            end
         end
         CHK_CLAIM: begin
            advance_pool(r, 1'b0);
            note = '{sspu_pkg::KIND_SPAWN, 6'(claim), 1'b1, 16'd0, 16'd0, r.w, r.h,
                     12'(sspu_pkg::RST_FRAME_ORIG), 1'b1};
            pending_reports.push_back(note);
         end
      endcase
      @(negedge clock);
   endtask

   function automatic sprite_req_type make_tick(logic [31:0] at);
      sprite_req_type r;
      // the unused fields still toggle
      r      = sprite_req_type'({$urandom, $urandom, $urandom});
      r.op   = sspu_pkg::OP_TICK;
      r.now  = at;
      return r;
   endfunction

   function automatic sprite_req_type make_spawn(logic [31:0] at, bit long_life);
      sprite_req_type r;
      r.op  = sspu_pkg::OP_SPAWN;
      r.now = at;
      r.vx  = 9'($urandom);
      r.vy  = 9'($urandom);
      r.w   = 6'($urandom);
      r.h   = 6'($urandom);
      if (long_life)                     r.life = 14'h3FFF;
      else if ($urandom_range(0, 1) == 0) r.life = 14'($urandom_range(100, 3000));
      else                               r.life = 14'($urandom);
      return r;
   endfunction

   // spawn until the pool is full and the last ones are refused
   task automatic crowd_pool();
      repeat (CROWD) transfer_item(make_spawn(clock_ms, 1'b1), CHK_MODEL, 0);
   endtask

   task automatic run_phase(int budget);
      int done;
      int n;
      int pick;
      sprite_req_type r;
      done = 0;
      while (done < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // burst of ticks, mostly short time steps, now and then a long jump
            n = $urandom_range(1, 6);
            repeat (n) begin
               if ($urandom_range(0, 7) == 0) clock_ms += $urandom_range(0, 20000);
               else                           clock_ms += $urandom_range(0, 120);
               transfer_item(make_tick(clock_ms), CHK_MODEL, 0);
            end
            done += n;
         end else if (pick < 82) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               clock_ms += $urandom_range(0, 10);
               transfer_item(make_spawn(clock_ms, 1'b0), CHK_MODEL, 0);
            end
            done += n;
         end else if (pick < 88) begin
            crowd_pool();
            done += CROWD;
         end else begin
            // noise: any opcode at an arbitrary time, possibly in the past
            r = make_spawn($urandom, 1'b0);
            r.op = 1'($urandom);
            transfer_item(r, CHK_MODEL, 0);
            done++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Registers: only written once the block has drained
   // ---------------------------------------------------------------------------
   task automatic settle();
      req_valid = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      // let the final report clear the output stage
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      case (idx)
         sspu_pkg::CSR_X_LOW:       bound_x_lo   = data[11:0];
         sspu_pkg::CSR_X_HIGH:      bound_x_hi   = data[11:0];
         sspu_pkg::CSR_Y_LOW:       bound_y_lo   = data[11:0];
         sspu_pkg::CSR_Y_HIGH:      bound_y_hi   = data[11:0];
         sspu_pkg::CSR_ANIM_PERIOD: anim_period  = data;
         sspu_pkg::CSR_FRAME_ORIG:  sheet_origin = data[9:0];
         sspu_pkg::CSR_FRAME_WIDTH: sheet_step   = data[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [11:0] xl, input logic [11:0] xh,
                                input logic [11:0] yl, input logic [11:0] yh,
                                input logic [15:0] period, input logic [9:0] origin,
                                input logic [7:0] step);
      // bounds go out sign-extended to the full write width
      write_csr(sspu_pkg::CSR_X_LOW,       {{4{xl[11]}}, xl});
      write_csr(sspu_pkg::CSR_X_HIGH,      {{4{xh[11]}}, xh});
      write_csr(sspu_pkg::CSR_Y_LOW,       {{4{yl[11]}}, yl});
      write_csr(sspu_pkg::CSR_Y_HIGH,      {{4{yh[11]}}, yh});
      write_csr(sspu_pkg::CSR_ANIM_PERIOD, period);
      write_csr(sspu_pkg::CSR_FRAME_ORIG,  16'(origin));
      write_csr(sspu_pkg::CSR_FRAME_WIDTH, 16'(step));
      csr_wr_en = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      sprite_req_type r;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = sspu_pkg::OP_TICK;
      req_now       = '0;
      req_vel_x     = '0;
      req_vel_y     = '0;
      req_width_in  = '0;
      req_height_in = '0;
      req_life_in   = '0;
      csr_wr_en     = 1'b0;
      csr_index     = sspu_pkg::CSR_X_LOW;
      csr_wdata     = '0;
      error_count   = 0;
      cycle_count   = 0;
      quiet         = 1'b0;
      hold_request  = 1'b0;
      foreach (pool_live[i]) pool_live[i] = 1'b0;
      bound_x_lo    = sspu_pkg::RST_X_LOW;
      bound_x_hi    = sspu_pkg::RST_X_HIGH;
      bound_y_lo    = sspu_pkg::RST_Y_LOW;
      bound_y_hi    = sspu_pkg::RST_Y_HIGH;
      anim_period   = sspu_pkg::RST_ANIM_PERIOD;
      sheet_origin  = sspu_pkg::RST_FRAME_ORIG;
      sheet_step    = sspu_pkg::RST_FRAME_WIDTH;

      repeat (8) @(negedge clock);
      reset = 1'b0;

      foreach (plan[k]) transfer_item(plan[k].req, plan[k].chk, plan[k].slot);
      clock_ms = 32'd100;

      // plausible screen-sized bounds
      settle();
      apply_setting(12'($urandom_range(0, 100)), 12'($urandom_range(100, 800)),
                    12'($urandom_range(0, 100)), 12'($urandom_range(100, 600)),
                    16'($urandom_range(0, 300)), 10'($urandom), 8'($urandom));
      run_phase(30);

      // widest bounds, zero period, largest sheet offsets. Two sprites at full
      // speed, ticked at 1 ms steps until their 16-bit positions wrap.
      settle();
      apply_setting(12'h800, 12'h7FF, 12'h800, 12'h7FF, 16'd0, 10'h3FF, 8'hFF);
      clock_ms += 20000;
      transfer_item(make_tick(clock_ms), CHK_MODEL, 0);
      r = '{sspu_pkg::OP_SPAWN, clock_ms, 9'h0FF, 9'h100, 6'd12, 6'd34, 14'h3FFF};
      transfer_item(r, CHK_MODEL, 0);
      r = '{sspu_pkg::OP_SPAWN, clock_ms, 9'h100, 9'h0FF, 6'd33, 6'd17, 14'h3FFF};
      transfer_item(r, CHK_MODEL, 0);
      repeat (132) begin
         clock_ms += 1;
         transfer_item(make_tick(clock_ms), CHK_MODEL, 0);
      end
      run_phase(10);

      // inverted bounds: every live sprite bounces on every tick; full pool refusal
      settle();
      apply_setting(12'h7FF, 12'h800, 12'h7FF, 12'h800, 16'hFFFF, 10'd0, 8'd0);
      crowd_pool();
      run_phase(10);

      // tight bounds; the receiver holds off while ticks keep coming
      settle();
      apply_setting(12'($urandom_range(0, 40)) - 12'd20, 12'($urandom_range(0, 40)) - 12'd20,
                    12'($urandom_range(0, 40)) - 12'd20, 12'($urandom_range(0, 40)) - 12'd20,
                    16'($urandom_range(0, 200)), 10'($urandom), 8'($urandom));
      hold_request = 1'b1;
      run_phase(30);

      // anything goes, with the time base just short of its wrap
      settle();
      apply_setting(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                    16'($urandom), 10'($urandom), 8'($urandom));
      clock_ms = 32'hFFFF_F000;
      run_phase(25);

      // back to reset values, both sides flat out
      settle();
      quiet = 1'b1;
      apply_setting(sspu_pkg::RST_X_LOW, sspu_pkg::RST_X_HIGH,
                    sspu_pkg::RST_Y_LOW, sspu_pkg::RST_Y_HIGH,
                    sspu_pkg::RST_ANIM_PERIOD, sspu_pkg::RST_FRAME_ORIG,
                    sspu_pkg::RST_FRAME_WIDTH);
      run_phase(25);

      req_valid = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      // catch any stray report after the last expected one
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sspu_pkg.sv
hw/rtl/sspu_slot_mem.sv
hw/rtl/sspu_slot_update.sv
hw/rtl/sprite_slot_pool_update_core.sv
verif/sprite_slot_pool_update_core_test.sv
